// ===== design/dpb_pkg.sv =====
// Shared types and constants for the depth pixel back-projection block.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package dpb_pkg;

    // Frame limits; a pixel at or beyond them gives no point.
    localparam logic [16:0] MAX_COLS = 17'd4096;
    localparam logic [16:0] MAX_ROWS = 17'd4096;

    // Register map, index = paddr[4:2]
    localparam logic [2:0] REG_DEPTH_SCALE_RECIP = 3'd0;
    localparam logic [2:0] REG_CENTER_X          = 3'd1;
    localparam logic [2:0] REG_CENTER_Y          = 3'd2;
    localparam logic [2:0] REG_FOCAL_X_RECIP     = 3'd3;
    localparam logic [2:0] REG_FOCAL_Y_RECIP     = 3'd4;

    localparam logic [23:0] RST_DEPTH_SCALE_RECIP = 24'd16777;
    localparam logic [19:0] RST_CENTER_X          = 20'd153992;
    localparam logic [19:0] RST_CENTER_Y          = 20'd94761;
    localparam logic [23:0] RST_FOCAL_X_RECIP     = 24'd25887;
    localparam logic [23:0] RST_FOCAL_Y_RECIP     = 24'd25887;

    typedef struct packed {
        logic [23:0] depth_scale_recip;
        logic [19:0] center_x;
        logic [19:0] center_y;
        logic [23:0] focal_x_recip;
        logic [23:0] focal_y_recip;
    } cfg_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } color_t;

    typedef struct packed {
        logic [11:0] pixel_row;
        logic [11:0] pixel_col;
        logic [15:0] depth_value;
        color_t      color;
    } pixel_t;

    // Between depth stage and projection stage
    typedef struct packed {
        logic [31:0] point_z;
        logic [44:0] prod_x;   // |dx| * focal_x_recip
        logic [44:0] prod_y;   // |dy| * focal_y_recip
        logic        neg_x;
        logic        neg_y;
        color_t      color;
    } front_t;

    typedef struct packed {
        logic signed [47:0] point_x;
        logic signed [47:0] point_y;
        logic [31:0]        point_z;
        color_t             color;
    } result_t;

endpackage

// ===== design/dpb_regs.sv =====
// APB configuration register file for the back-projection block.
// Depends on dpb_pkg for the register map, reset values and cfg_t.
`timescale 1ns / 1ps

module dpb_regs (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready,
    output dpb_pkg::cfg_t cfg
);
    import dpb_pkg::*;

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic       wr_en;
    logic [2:0] idx;

    assign pready = 1'b1;
    assign idx    = paddr[4:2];
    assign wr_en  = psel && penable && pwrite && pready;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (idx)
                REG_DEPTH_SCALE_RECIP: cfg_next.depth_scale_recip = pwdata[23:0];
                REG_CENTER_X:          cfg_next.center_x          = pwdata[19:0];
                REG_CENTER_Y:          cfg_next.center_y          = pwdata[19:0];
                REG_FOCAL_X_RECIP:     cfg_next.focal_x_recip     = pwdata[23:0];
                REG_FOCAL_Y_RECIP:     cfg_next.focal_y_recip     = pwdata[23:0];
                default:               cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_DEPTH_SCALE_RECIP: prdata = {8'd0, cfg_reg.depth_scale_recip};
            REG_CENTER_X:          prdata = {12'd0, cfg_reg.center_x};
            REG_CENTER_Y:          prdata = {12'd0, cfg_reg.center_y};
            REG_FOCAL_X_RECIP:     prdata = {8'd0, cfg_reg.focal_x_recip};
            REG_FOCAL_Y_RECIP:     prdata = {8'd0, cfg_reg.focal_y_recip};
            default:               prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.depth_scale_recip <= RST_DEPTH_SCALE_RECIP;
            cfg_reg.center_x          <= RST_CENTER_X;
            cfg_reg.center_y          <= RST_CENTER_Y;
            cfg_reg.focal_x_recip     <= RST_FOCAL_X_RECIP;
            cfg_reg.focal_y_recip     <= RST_FOCAL_Y_RECIP;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ===== design/dpb_depth_stage.sv =====
// Front pipeline stages 1-2: pixel filter, depth scaling, center offsets
// and focal reciprocal products. Depends on dpb_pkg.
`timescale 1ns / 1ps

module dpb_depth_stage (
    input  logic            clk,
    input  logic            rst_n,
    input  dpb_pkg::cfg_t   cfg,
    input  logic            in_valid,
    output logic            in_ready,
    input  dpb_pkg::pixel_t in_pix,
    output logic            out_valid,
    input  logic            out_ready,
    output dpb_pkg::front_t out_data
);
    import dpb_pkg::*;

    // stage 1
    logic        s1_valid_reg, s1_valid_next;
    logic        s1_ready;
    logic [39:0] prod_z_reg, prod_z_next;
    logic [20:0] mag_x_reg, mag_x_next;
    logic [20:0] mag_y_reg, mag_y_next;
    logic        neg_x_reg, neg_x_next;
    logic        neg_y_reg, neg_y_next;
    color_t      color_reg;
    logic        keep;
    logic [20:0] dx;
    logic [20:0] dy;

    // stage 2
    logic        s2_valid_reg, s2_valid_next;
    logic        s2_ready;
    front_t      s2_reg, s2_next;
    logic [40:0] z_sum;

    assign s2_ready  = !s2_valid_reg || out_ready;
    assign s1_ready  = !s1_valid_reg || s2_ready;
    assign in_ready  = s1_ready;
    assign out_valid = s2_valid_reg;
    assign out_data  = s2_reg;

    always_comb
    begin
        keep = (in_pix.depth_value != 16'd0)
            && ({5'd0, in_pix.pixel_row} < MAX_ROWS)
            && ({5'd0, in_pix.pixel_col} < MAX_COLS);
        s1_valid_next = s1_ready ? (in_valid && keep) : s1_valid_reg;

        prod_z_next = 40'(in_pix.depth_value) * 40'(cfg.depth_scale_recip);
        // offsets in Q.8 pixels, 21-bit two's complement
        dx = {1'b0, in_pix.pixel_col, 8'd0} - {1'b0, cfg.center_x};
        dy = {1'b0, in_pix.pixel_row, 8'd0} - {1'b0, cfg.center_y};
        mag_x_next = dx[20] ? (21'd0 - dx) : dx;
        mag_y_next = dy[20] ? (21'd0 - dy) : dy;
        neg_x_next = dx[20];
        neg_y_next = !dy[20];          // y axis points up
    end

    always_comb
    begin
        s2_valid_next = s2_ready ? s1_valid_reg : s2_valid_reg;
        z_sum = {1'b0, prod_z_reg} + 41'd128;     // round Q.24 to Q.16
        s2_next.point_z = z_sum[39:8];
        s2_next.prod_x  = 45'(mag_x_reg) * 45'(cfg.focal_x_recip);
        s2_next.prod_y  = 45'(mag_y_reg) * 45'(cfg.focal_y_recip);
        s2_next.neg_x   = neg_x_reg;
        s2_next.neg_y   = neg_y_reg;
        s2_next.color   = color_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready)
        begin
            prod_z_reg <= prod_z_next;
            mag_x_reg  <= mag_x_next;
            mag_y_reg  <= mag_y_next;
            neg_x_reg  <= neg_x_next;
            neg_y_reg  <= neg_y_next;
            color_reg  <= in_pix.color;
        end
        if (s2_ready)
        begin
            s2_reg <= s2_next;
        end
    end

    // dropped pixels never occupy the pipe
    a_drop_zero: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (in_pix.depth_value == 16'd0) |=> !s1_valid_reg)
        else $error("zero-depth pixel entered the pipeline");

    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s2_ready |=> s1_valid_reg && $stable(prod_z_reg))
        else $error("stage 1 lost data during a stall");

    a_mag_range: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg |-> (mag_x_reg <= 21'h100000) && (mag_y_reg <= 21'h100000))
        else $error("offset magnitude out of range");

endmodule

// ===== design/dpb_project_stage.sv =====
// Back pipeline stages 3-5: split 45x32 products, rounding to Q32.16,
// sign application and the output register. Depends on dpb_pkg.
`timescale 1ns / 1ps

module dpb_project_stage (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  dpb_pkg::front_t  in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output dpb_pkg::result_t out_data
);
    import dpb_pkg::*;

    // stage 3: partial products, high part of the 45-bit operand is 23 bits
    logic        s3_valid_reg, s3_valid_next;
    logic        s3_ready;
    logic [54:0] pxh_reg, pxh_next;
    logic [53:0] pxl_reg, pxl_next;
    logic [54:0] pyh_reg, pyh_next;
    logic [53:0] pyl_reg, pyl_next;
    logic [31:0] z3_reg;
    logic        neg_x3_reg, neg_y3_reg;
    color_t      color3_reg;

    // stage 4: full product, rounded half up to Q.16
    logic        s4_valid_reg, s4_valid_next;
    logic        s4_ready;
    logic [44:0] rx_reg, rx_next;
    logic [44:0] ry_reg, ry_next;
    logic [31:0] z4_reg;
    logic        neg_x4_reg, neg_y4_reg;
    color_t      color4_reg;
    logic [76:0] sum_x, sum_y;

    // stage 5: output register
    logic        s5_valid_reg, s5_valid_next;
    logic        s5_ready;
    result_t     s5_reg, s5_next;

    assign s5_ready  = !s5_valid_reg || out_ready;
    assign s4_ready  = !s4_valid_reg || s5_ready;
    assign s3_ready  = !s3_valid_reg || s4_ready;
    assign in_ready  = s3_ready;
    assign out_valid = s5_valid_reg;
    assign out_data  = s5_reg;

    always_comb
    begin
        s3_valid_next = s3_ready ? in_valid : s3_valid_reg;
        pxh_next = 55'(in_data.prod_x[44:22]) * 55'(in_data.point_z);
        pxl_next = 54'(in_data.prod_x[21:0]) * 54'(in_data.point_z);
        pyh_next = 55'(in_data.prod_y[44:22]) * 55'(in_data.point_z);
        pyl_next = 54'(in_data.prod_y[21:0]) * 54'(in_data.point_z);
    end

    always_comb
    begin
        s4_valid_next = s4_ready ? s3_valid_reg : s4_valid_reg;
        sum_x = {pxh_reg, 22'd0} + {23'd0, pxl_reg} + (77'd1 << 31);
        sum_y = {pyh_reg, 22'd0} + {23'd0, pyl_reg} + (77'd1 << 31);
        rx_next = sum_x[76:32];
        ry_next = sum_y[76:32];
    end

    always_comb
    begin
        s5_valid_next   = s5_ready ? s4_valid_reg : s5_valid_reg;
        // magnitude stays below 2^45, so no saturation is reachable
        s5_next.point_x = neg_x4_reg ? (48'sd0 - $signed({3'd0, rx_reg}))
                                     : $signed({3'd0, rx_reg});
        s5_next.point_y = neg_y4_reg ? (48'sd0 - $signed({3'd0, ry_reg}))
                                     : $signed({3'd0, ry_reg});
        s5_next.point_z = z4_reg;
        s5_next.color   = color4_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
        end
        else
        begin
            s3_valid_reg <= s3_valid_next;
            s4_valid_reg <= s4_valid_next;
            s5_valid_reg <= s5_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s3_ready)
        begin
            pxh_reg    <= pxh_next;
            pxl_reg    <= pxl_next;
            pyh_reg    <= pyh_next;
            pyl_reg    <= pyl_next;
            z3_reg     <= in_data.point_z;
            neg_x3_reg <= in_data.neg_x;
            neg_y3_reg <= in_data.neg_y;
            color3_reg <= in_data.color;
        end
        if (s4_ready)
        begin
            rx_reg     <= rx_next;
            ry_reg     <= ry_next;
            z4_reg     <= z3_reg;
            neg_x4_reg <= neg_x3_reg;
            neg_y4_reg <= neg_y3_reg;
            color4_reg <= color3_reg;
        end
        if (s5_ready)
        begin
            s5_reg <= s5_next;
        end
    end

    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        s4_valid_reg && s5_ready |=> s5_valid_reg)
        else $error("stage 4 item did not reach the output register");

    a_s3_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s3_valid_reg && !s4_ready |=> s3_valid_reg && $stable(z3_reg))
        else $error("stage 3 lost data during a stall");

    a_x_range: assert property (@(posedge clk) disable iff (!rst_n)
        s5_valid_reg |-> (s5_reg.point_x[47:45] == 3'b000)
                      || (s5_reg.point_x[47:45] == 3'b111))
        else $error("point_x magnitude beyond 2^45");

endmodule

// ===== design/depth_pixel_backprojection.sv =====
// Top level of the depth pixel back-projection block.
// Depends on dpb_pkg, dpb_regs, dpb_depth_stage and dpb_project_stage.
`timescale 1ns / 1ps

// Usage:
//   s_* : one depth pixel per request (row, column, raw depth, BGR bytes).
//   m_* : one 3D point per request (x, y in signed Q32.16 m, z in Q16.16 m,
//         BGR bytes passed through). A pixel with zero depth or outside the
//         frame is accepted and yields no point.
//   APB : five camera registers at byte addresses 0x00..0x10; pready is
//         tied high, writes land on the access cycle. Write only when idle.
// Throughput: one pixel per clock while m_tready is high. Each of the five pipeline
//   registers has its own valid bit and a ready that only looks at the
//   next stage, so bubbles close up and s_tready stays high while the
//   output holds a point that is not yet taken, as long as a slot is free.
// Path: a point shows on m_tvalid once its pixel has passed the five
//   pipeline registers in order (depth product, z rounding and focal
//   products, split 45x32 products, rounding, sign and output register).
// Reset: rst_n clears all valid bits and loads the default camera
//   registers. A stalled m_tready holds the point and fills the pipe,
//   then s_tready drops; nothing is lost or repeated.
module depth_pixel_backprojection (
    input  logic         clk,
    input  logic         rst_n,
    // pixel stream
    input  logic         s_tvalid,
    output logic         s_tready,
    // [11:0] pixel_row, [23:12] pixel_col, [39:24] depth_value,
    // [47:40] blue, [55:48] green, [63:56] red
    input  logic [63:0]  s_tdata,
    // point stream
    output logic         m_tvalid,
    input  logic         m_tready,
    // [47:0] point_x, [95:48] point_y, [127:96] point_z,
    // [135:128] out_blue, [143:136] out_green, [151:144] out_red
    output logic [151:0] m_tdata,
    // configuration
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    import dpb_pkg::*;

    cfg_t    cfg;
    pixel_t  pix;
    front_t  front;
    logic    front_valid;
    logic    front_ready;
    result_t point;

    // unpack the input request
    always_comb
    begin
        pix.pixel_row   = s_tdata[11:0];
        pix.pixel_col   = s_tdata[23:12];
        pix.depth_value = s_tdata[39:24];
        pix.color.blue  = s_tdata[47:40];
        pix.color.green = s_tdata[55:48];
        pix.color.red   = s_tdata[63:56];
    end

    dpb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // stages 1-2
    dpb_depth_stage u_depth (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_pix    (pix),
        .out_valid (front_valid),
        .out_ready (front_ready),
        .out_data  (front)
    );

    // stages 3-5
    dpb_project_stage u_project (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (front_valid),
        .in_ready  (front_ready),
        .in_data   (front),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (point)
    );

    assign m_tdata = {point.color.red, point.color.green, point.color.blue,
                      point.point_z, point.point_y, point.point_x};

endmodule
